// ===== rtl/kppe_pkg.sv =====
`default_nettype none

package kppe_pkg;

	localparam int unsigned KEYS       = 10;
	localparam int unsigned MIN_DIGITS = 4;
	localparam int unsigned MAX_DIGITS = 10;

	localparam int unsigned WORD_W     = 32;
	localparam int unsigned KEY_W      = 4;
	localparam int unsigned CHAR_W     = 6;
	localparam int unsigned STATUS_W   = 2;

	// The divider retires this many quotient bits per cycle.
	localparam int unsigned STEP_BITS  = 8;
	localparam int unsigned DIV_PASSES = WORD_W / STEP_BITS;
	localparam int unsigned PASS_W     = $clog2(DIV_PASSES);

	localparam logic [CHAR_W-1:0]   ASCII_ZERO = 6'h30;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_LONG  = 2'd2;

	typedef struct packed {
		logic [WORD_W-1:0] num;
		logic [KEY_W-1:0]  rem;
	} div_res_t;

	// One pass of restoring division by a divisor of at most ten. The top
	// bits of the dividend are consumed and quotient bits enter at the bottom.
	function automatic div_res_t div_step(input logic [WORD_W-1:0] num,
			input logic [KEY_W-1:0] rem, input logic [KEY_W-1:0] den);
		div_res_t             res;
		logic [KEY_W:0]       trial;
		logic [KEY_W-1:0]     r;
		logic [STEP_BITS-1:0] qb;
		r  = rem;
		qb = '0;
		for (int i = 0; i < STEP_BITS; i++) begin
			trial = {r, num[WORD_W-1-i]};
			if (trial >= {1'b0, den}) begin
				r = KEY_W'(trial - {1'b0, den});
				qb[STEP_BITS-1-i] = 1'b1;
			end else begin
				r = trial[KEY_W-1:0];
			end
		end
		res.num = {num[WORD_W-STEP_BITS-1:0], qb};
		res.rem = r;
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/keypad_permuted_pin_encoder.sv =====
`default_nettype none

// Channel   Direction  Item
// s_axis    in         PIN, s_tdata[31:0] = pin_value
// m_axis    out        one key or one error, m_tdata fields below, tlast = last
// cfg       in         layout seed write, no read-back
//
// A 32-bit division runs on the shared divider, 8 quotient bits a cycle.
// A PIN is divided by ten until the quotient is zero, then its keys are emitted.
// A seed write rebuilds the layout, one division per keypad position;
// s_tready is low meanwhile. Reset gives the identity layout at once.
// A stalled output holds the block; the next PIN is taken after the last result.

module keypad_permuted_pin_encoder (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [kppe_pkg::WORD_W-1:0]  s_tdata,   // [31:0] pin_value
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [7:0]                        m_tdata,   // [5:0] key_char, [7:6] status
	output logic                              m_tlast,
	input  wire logic                         cfg_wr_en,
	input  wire logic [kppe_pkg::WORD_W-1:0]  cfg_wr_data
);
	import kppe_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SEED = 2'd1;
	localparam logic [1:0] S_PIN  = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	logic [1:0]        state_q;
	logic [PASS_W-1:0] pass_q;
	logic [KEY_W-1:0]  radix_q;
	logic [KEY_W-1:0]  dig_cnt_q;
	logic [KEY_W-1:0]  left_q;
	logic [WORD_W-1:0] num_q;
	logic [KEY_W-1:0]  rem_q;
	logic [KEY_W-1:0]  pool_q [KEYS];
	logic [KEY_W-1:0]  digs_q [KEYS];
	logic [KEY_W-1:0]  digit_position_q [KEYS];

	logic [KEY_W-1:0]  den;
	div_res_t          div;
	logic              div_last;
	logic              fin;
	logic              too_long;
	logic              too_short;
	logic [CHAR_W-1:0] top_char;
	logic [KEY_W-1:0]  pos;

	assign den       = (state_q == S_SEED) ? radix_q : KEY_W'(KEYS);
	assign div       = div_step(num_q, rem_q, den);
	assign div_last  = (pass_q == PASS_W'(DIV_PASSES - 1));
	assign fin       = (state_q == S_PIN) && (pass_q == '0) && (num_q == '0);
	assign too_long  = (dig_cnt_q > KEY_W'(MAX_DIGITS));
	assign too_short = (dig_cnt_q < KEY_W'(MIN_DIGITS));
	assign top_char  = ASCII_ZERO + {2'b00, digit_position_q[digs_q[KEYS-1]]};
	assign pos       = KEY_W'(KEYS) - radix_q;
	assign s_tready  = (state_q == S_IDLE) && !cfg_wr_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pass_q    <= '0;
			radix_q   <= '0;
			dig_cnt_q <= '0;
			left_q    <= '0;
			m_tvalid  <= 1'b0;
			for (int d = 0; d < KEYS; d++) begin
				digit_position_q[d] <= KEY_W'(d);
			end
		end else if (cfg_wr_en) begin
			state_q <= S_SEED;
			pass_q  <= '0;
			radix_q <= KEY_W'(KEYS);
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q   <= S_PIN;
						pass_q    <= '0;
						dig_cnt_q <= '0;
					end
				end
				S_SEED: begin
					pass_q <= pass_q + 1'b1;
					if (div_last) begin
						digit_position_q[pool_q[div.rem]] <= pos;
						radix_q <= radix_q - 1'b1;
						if (radix_q == KEY_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_PIN: begin
					if (fin) begin
						m_tvalid <= 1'b1;
						state_q  <= S_EMIT;
						left_q   <= (too_long || too_short) ? '0 : dig_cnt_q - 1'b1;
					end else begin
						pass_q <= pass_q + 1'b1;
						if (div_last) begin
							dig_cnt_q <= dig_cnt_q + 1'b1;
						end
					end
				end
				S_EMIT: begin
					if (m_tready) begin
						if (left_q == '0) begin
							m_tvalid <= 1'b0;
							state_q  <= S_IDLE;
						end else begin
							left_q <= left_q - 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cfg_wr_en) begin
			num_q <= cfg_wr_data;
			rem_q <= '0;
			for (int k = 0; k < KEYS; k++) begin
				pool_q[k] <= KEY_W'(k);
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						num_q <= s_tdata;
						rem_q <= '0;
					end
				end
				S_SEED: begin
					num_q <= div.num;
					rem_q <= div_last ? '0 : div.rem;
					if (div_last) begin
						for (int k = 0; k < KEYS - 1; k++) begin
							if (KEY_W'(k) >= div.rem) begin
								pool_q[k] <= pool_q[k+1];
							end
						end
					end
				end
				S_PIN: begin
					if (fin) begin
						if (too_long) begin
							m_tdata <= {ST_LONG, {CHAR_W{1'b0}}};
							m_tlast <= 1'b1;
						end else if (too_short) begin
							m_tdata <= {ST_SHORT, {CHAR_W{1'b0}}};
							m_tlast <= 1'b1;
						end else begin
							m_tdata <= {ST_OK, top_char};
							m_tlast <= (dig_cnt_q == KEY_W'(1));
							for (int k = 0; k < KEYS - 1; k++) begin
								digs_q[k+1] <= digs_q[k];
							end
						end
					end else begin
						num_q <= div.num;
						rem_q <= div_last ? '0 : div.rem;
						if (div_last) begin
							digs_q[KEYS-1] <= div.rem;
							for (int k = 0; k < KEYS - 1; k++) begin
								digs_q[k] <= digs_q[k+1];
							end
						end
					end
				end
				S_EMIT: begin
					if (m_tready && (left_q != '0)) begin
						m_tdata <= {ST_OK, top_char};
						m_tlast <= (left_q == KEY_W'(1));
						for (int k = 0; k < KEYS - 1; k++) begin
							digs_q[k+1] <= digs_q[k];
						end
					end
				end
				default: begin
					num_q <= num_q;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
